[rtl/pmta_pkg.sv]
// ----------------------------------------------------------------------------
// Priority/mutex task arbiter package
// Shared widths, defaults and operation codes for the task arbiter.
// ----------------------------------------------------------------------------
package pmta_pkg;

    localparam int DEF_MAX_TASKS   = 8;
    localparam int DEF_MUTEX_WIDTH = 8;

    localparam int RANK_W  = 8;
    localparam int MASK_W  = 8;
    localparam int INMTX_W = 8;
    localparam int TOTAL_W = 4;

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_TICK = 1'b1;

endpackage

[rtl/priority_mutex_task_arbiter_top.sv]
// ----------------------------------------------------------------------------
// Priority/mutex task arbiter
// Holds a task table and runs scheduling ticks over it, one task per cycle.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. An add item finishes
// at the edge that takes it, and its result appears with done in the next
// cycle. A tick item walks the held tasks in insertion order, one task per
// cycle through a single blocking-check unit, so busy stays high while the
// walk runs (never for an empty table) and done follows in the cycle after
// the walk. The result is shown for exactly one cycle while
// done is high and cannot be held off; a new item may be given in that cycle.
module priority_mutex_task_arbiter_top #(
    parameter int MAX_TASKS   = pmta_pkg::DEF_MAX_TASKS,
    parameter int MUTEX_WIDTH = pmta_pkg::DEF_MUTEX_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          operation,
    input  logic [pmta_pkg::RANK_W-1:0]   priority_req,
    input  logic [pmta_pkg::INMTX_W-1:0]  mutex_bits,
    input  logic                          interruptible,
    input  logic [pmta_pkg::MASK_W-1:0]   want_start_mask,
    input  logic [pmta_pkg::MASK_W-1:0]   want_continue_mask,
    output logic                          done,
    output logic [pmta_pkg::MASK_W-1:0]   executing_mask,
    output logic [pmta_pkg::MASK_W-1:0]   started_mask,
    output logic [pmta_pkg::MASK_W-1:0]   stopped_mask,
    output logic                          table_full,
    output logic [pmta_pkg::TOTAL_W-1:0]  task_total
);
    import pmta_pkg::*;

    localparam int IDX_W = $clog2(MAX_TASKS);
    localparam int CNT_W = $clog2(MAX_TASKS + 1);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_WALK = 1'b1;

    logic                                 state_reg, state_next;
    logic [IDX_W-1:0]                     idx_reg, idx_next;
    logic [CNT_W-1:0]                     count_reg, count_next;
    logic [MAX_TASKS-1:0]                 run_reg, run_next;
    logic [MAX_TASKS-1:0]                 started_reg, started_next;
    logic [MAX_TASKS-1:0]                 stopped_reg, stopped_next;
    logic [MAX_TASKS-1:0]                 want_reg, want_next;
    logic [MAX_TASKS-1:0]                 cont_reg, cont_next;
    logic                                 full_reg, full_next;
    logic                                 done_reg, done_next;

    logic [MAX_TASKS-1:0][RANK_W-1:0]     rank_reg;
    logic [MAX_TASKS-1:0][MUTEX_WIDTH-1:0] mutex_reg;
    logic [MAX_TASKS-1:0]                 preempt_reg;

    logic                                 accept;
    logic                                 is_full;
    logic                                 add_ok;
    logic                                 allowed;
    logic                                 last;
    logic                                 cur_run;
    logic                                 cur_stop;
    logic                                 cur_start;
    logic [MAX_TASKS-1:0]                 cur_bit;

    logic [MUTEX_WIDTH+INMTX_W-1:0]       mutex_wide;
    logic [MAX_TASKS+MASK_W-1:0]          want_wide;
    logic [MAX_TASKS+MASK_W-1:0]          cont_wide;
    logic [MASK_W+MAX_TASKS-1:0]          exec_wide;
    logic [MASK_W+MAX_TASKS-1:0]          start_wide;
    logic [MASK_W+MAX_TASKS-1:0]          stop_wide;
    logic [TOTAL_W+CNT_W-1:0]             total_wide;

    assign accept  = start && (state_reg == S_IDLE);
    assign is_full = (count_reg == CNT_W'(MAX_TASKS));
    assign add_ok  = accept && (operation == OP_ADD) && !is_full;

    assign mutex_wide = {{MUTEX_WIDTH{1'b0}}, mutex_bits};
    assign want_wide  = {{MAX_TASKS{1'b0}}, want_start_mask};
    assign cont_wide  = {{MAX_TASKS{1'b0}}, want_continue_mask};

    pmta_block_check #(
        .MAX_TASKS   (MAX_TASKS),
        .MUTEX_WIDTH (MUTEX_WIDTH),
        .IDX_W       (IDX_W)
    ) u_check (
        .cand_idx    (idx_reg),
        .rank_all    (rank_reg),
        .mutex_all   (mutex_reg),
        .preempt_all (preempt_reg),
        .run_set     (run_reg),
        .allowed     (allowed)
    );

    assign cur_bit   = MAX_TASKS'(1) << idx_reg;
    assign cur_run   = run_reg[idx_reg];
    assign cur_stop  = cur_run && (!allowed || !cont_reg[idx_reg]);
    assign cur_start = (!cur_run || cur_stop) && allowed && want_reg[idx_reg];
    assign last      = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);

    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        count_next   = count_reg;
        run_next     = run_reg;
        started_next = started_reg;
        stopped_next = stopped_reg;
        want_next    = want_reg;
        cont_next    = cont_reg;
        full_next    = full_reg;
        done_next    = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    started_next = '0;
                    stopped_next = '0;
                    if (operation == OP_ADD)
                    begin
                        full_next = is_full;
                        done_next = 1'b1;
                        if (!is_full)
                        begin
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    else
                    begin
                        full_next = 1'b0;
                        want_next = want_wide[MAX_TASKS-1:0];
                        cont_next = cont_wide[MAX_TASKS-1:0];
                        idx_next  = '0;
                        if (count_reg == '0)
                        begin
                            done_next = 1'b1;
                        end
                        else
                        begin
                            state_next = S_WALK;
                        end
                    end
                end
            end
            S_WALK:
            begin
                run_next = run_reg;
                if (cur_stop)
                begin
                    run_next     = run_next & ~cur_bit;
                    stopped_next = stopped_reg | cur_bit;
                end
                if (cur_start)
                begin
                    run_next     = run_next | cur_bit;
                    started_next = started_reg | cur_bit;
                end
                idx_next = idx_reg + IDX_W'(1);
                if (last)
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            idx_reg     <= '0;
            count_reg   <= '0;
            run_reg     <= '0;
            started_reg <= '0;
            stopped_reg <= '0;
            want_reg    <= '0;
            cont_reg    <= '0;
            full_reg    <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            count_reg   <= count_next;
            run_reg     <= run_next;
            started_reg <= started_next;
            stopped_reg <= stopped_next;
            want_reg    <= want_next;
            cont_reg    <= cont_next;
            full_reg    <= full_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (add_ok)
        begin
            rank_reg[count_reg[IDX_W-1:0]]    <= priority_req;
            mutex_reg[count_reg[IDX_W-1:0]]   <= mutex_wide[MUTEX_WIDTH-1:0];
            preempt_reg[count_reg[IDX_W-1:0]] <= interruptible;
        end
    end

    assign exec_wide  = {{MASK_W{1'b0}}, run_reg};
    assign start_wide = {{MASK_W{1'b0}}, started_reg};
    assign stop_wide  = {{MASK_W{1'b0}}, stopped_reg};
    assign total_wide = {{TOTAL_W{1'b0}}, count_reg};

    assign busy           = (state_reg == S_WALK);
    assign done           = done_reg;
    assign executing_mask = exec_wide[MASK_W-1:0];
    assign started_mask   = start_wide[MASK_W-1:0];
    assign stopped_mask   = stop_wide[MASK_W-1:0];
    assign table_full     = full_reg;
    assign task_total     = total_wide[TOTAL_W-1:0];

endmodule

[rtl/pmta_block_check.sv]
// ----------------------------------------------------------------------------
// Blocking check
// Tests one candidate task against every executing task of the table.
// ----------------------------------------------------------------------------
module pmta_block_check #(
    parameter int MAX_TASKS   = 8,
    parameter int MUTEX_WIDTH = 8,
    parameter int IDX_W       = 3
) (
    input  logic [IDX_W-1:0]                              cand_idx,
    input  logic [MAX_TASKS-1:0][pmta_pkg::RANK_W-1:0]    rank_all,
    input  logic [MAX_TASKS-1:0][MUTEX_WIDTH-1:0]         mutex_all,
    input  logic [MAX_TASKS-1:0]                          preempt_all,
    input  logic [MAX_TASKS-1:0]                          run_set,
    output logic                                          allowed
);
    import pmta_pkg::*;

    logic [RANK_W-1:0]      cand_rank;
    logic [MUTEX_WIDTH-1:0] cand_mutex;
    logic [MAX_TASKS-1:0]   blk;

    assign cand_rank  = rank_all[cand_idx];
    assign cand_mutex = mutex_all[cand_idx];

    always_comb
    begin
        for (int y = 0; y < MAX_TASKS; y++)
        begin
            if (!run_set[y] || (IDX_W'(y) == cand_idx))
            begin
                blk[y] = 1'b0;
            end
            else if (cand_rank >= rank_all[y])
            begin
                blk[y] = |(cand_mutex & mutex_all[y]);
            end
            else
            begin
                blk[y] = ~preempt_all[y];
            end
        end
    end

    assign allowed = ~|blk;

endmodule
